// ===== hdl/spq_pkg.sv =====
// Package for the sorted priority queue: depth, widths, operation and status codes,
// and the control bundle that the top level broadcasts to every cell.
// Used by spq_cell and sorted_priority_queue_unit.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int VALUE_W     = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int COUNT_OUT_W = 5;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          count_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to all cells in the cycle a beat is accepted.
  typedef struct packed {
    logic push;   // insert in_value, queue not full
    logic pop;    // shift everything one place toward the head
    logic mode;   // 0: larger first, 1: smaller first
  } cell_ctrl_t;

endpackage

// ===== hdl/spq_cell.sv =====
// One storage cell of the sorted priority queue. It compares the incoming value with
// its own entry and takes its left neighbor, the new value, or its right neighbor.
// Depends on spq_pkg.
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::value_t   new_value,
  input  logic              occupied,
  input  logic              prev_take,
  input  spq_pkg::value_t   left_value,
  input  spq_pkg::value_t   right_value,
  output logic              take,
  output spq_pkg::value_t   value_r,
  output spq_pkg::value_t   value_nxt
);
  import spq_pkg::*;

  logic beats;
  logic hit;

  // The newcomer goes ahead of an entry it strictly beats; ties stay behind.
  assign beats = ctrl.mode ? (value_r > new_value) : (new_value > value_r);

  // An empty cell always accepts, so an append lands at the first free cell.
  assign hit = !occupied || beats;

  // Once any cell toward the head has taken the newcomer, every later cell shifts,
  // even when the stored order no longer matches the current mode.
  assign take = prev_take || hit;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.push && take) begin
      value_nxt = prev_take ? left_value : new_value;
    end else if (ctrl.pop) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== hdl/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: operation decode, entry count, the row of
// spq_cell instances and the registered result stage.
// Depends on spq_pkg and spq_cell.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+-------------------------------------
//  in_      | input     | in_valid / in_stall  | in_op, in_value
//  out_     | output    | out_valid / out_stall| out_popped_value, out_status,
//           |           |                      | out_head_value, out_is_empty,
//           |           |                      | out_entry_count
//  cfg_     | input     | cfg_valid / cfg_ready| cfg_order_mode
//
// All cells compare against the new value and shift in parallel, and the result is
// registered, so a beat can be accepted every cycle unless in_stall is high.
// The result beat appears in the cycle after its input beat is accepted.
// Reset empties the queue and selects larger-first order; entries are not cleared.
// in_stall is raised only while a result is held and out_stall is high.
module sorted_priority_queue_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spq_pkg::OP_W-1:0]      in_op,
  input  spq_pkg::value_t               in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output spq_pkg::value_t               out_popped_value,
  output logic [spq_pkg::STATUS_W-1:0]  out_status,
  output spq_pkg::value_t               out_head_value,
  output logic                          out_is_empty,
  output logic [spq_pkg::COUNT_OUT_W-1:0] out_entry_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_order_mode
);
  import spq_pkg::*;

  logic       accept;
  logic       order_mode_r;
  count_t     count_r, count_nxt;
  cell_ctrl_t ctrl;
  status_t    status;
  value_t     popped;
  logic       is_full, is_empty_now;
  logic [31:0] count_ext;

  logic   [QUEUE_DEPTH-1:0] occupied;
  logic   [QUEUE_DEPTH-1:0] take;
  value_t                   cell_value [QUEUE_DEPTH];
  value_t                   cell_nxt   [QUEUE_DEPTH];

  logic       out_valid_r;
  value_t     out_popped_value_r;
  status_t    out_status_r;
  value_t     out_head_value_r;
  logic       out_is_empty_r;
  logic [COUNT_OUT_W-1:0] out_entry_count_r;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign is_full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty_now = (count_r == '0);

  // Operation decoder.
  always_comb begin
    ctrl      = '0;
    ctrl.mode = order_mode_r;
    status    = ST_OK;
    popped    = '0;
    count_nxt = count_r;
    if (accept) begin
      unique case (in_op)
        OP_PUSH: begin
          if (is_full) begin
            status = ST_FULL;
          end else begin
            ctrl.push = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_POP: begin
          if (is_empty_now) begin
            status = ST_EMPTY;
          end else begin
            ctrl.pop  = 1'b1;
            popped    = cell_value[0];
            count_nxt = count_r - 1'b1;
          end
        end
        OP_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      assign occupied[g] = (CNT_W'(g) < count_r);
      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .new_value   (in_value),
        .occupied    (occupied[g]),
        .prev_take   ((g == 0) ? 1'b0 : take[(g == 0) ? 0 : g-1]),
        .left_value  (cell_value[(g == 0) ? 0 : g-1]),
        .right_value (cell_value[(g == QUEUE_DEPTH-1) ? g : g+1]),
        .take        (take[g]),
        .value_r     (cell_value[g]),
        .value_nxt   (cell_nxt[g])
      );
    end
  endgenerate

  assign count_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      order_mode_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        order_mode_r <= cfg_order_mode;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; the head comes from cell zero's next value.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_popped_value_r <= popped;
      out_status_r       <= status;
      out_head_value_r   <= (count_nxt == '0) ? '0 : cell_nxt[0];
      out_is_empty_r     <= (count_nxt == '0);
      out_entry_count_r  <= count_ext[COUNT_OUT_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_value_r;
  assign out_status       = out_status_r;
  assign out_head_value   = out_head_value_r;
  assign out_is_empty     = out_is_empty_r;
  assign out_entry_count  = out_entry_count_r;

endmodule

// ===== tb/pq_shadow_pkg.sv =====
// Shadow model and result checker for the sorted priority queue testbench.
// Mirrors the queue contents and the service order, and holds the results still owed.
// Depends on spq_pkg.
package pq_shadow_pkg;

  import spq_pkg::*;

  typedef struct {
    value_t                 popped;
    logic [STATUS_W-1:0]    status;
    value_t                 head;
    logic                   empty;
    logic [COUNT_OUT_W-1:0] count;
  } pq_result_t;

  class pq_shadow;
    value_t     entries[QUEUE_DEPTH];
    int         count;
    logic       serve_smaller;
    pq_result_t awaited[$];
    int         mismatches;
    int         results_seen;

    function new();
      count         = 0;
      serve_smaller = 1'b0;
      mismatches    = 0;
      results_seen  = 0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    function void set_order(logic mode);
      serve_smaller = mode;
    endfunction

    // Strict comparison, so a newcomer lands behind entries equal to it.
    function bit ranks_ahead(value_t newcomer, value_t existing);
      return serve_smaller ? (newcomer < existing) : (newcomer > existing);
    endfunction

    function void note_command(logic [OP_W-1:0] op, value_t val);
      pq_result_t r;
      int         slot;
      bit         placed;
      r.popped = '0;
      r.status = ST_OK;
      case (op)
        OP_PUSH: begin
          if (count >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slot   = count;
            placed = 1'b0;
            for (int i = 0; i < count; i++) begin
              if (!placed && ranks_ahead(val, entries[i])) begin
                slot   = i;
                placed = 1'b1;
              end
            end
            for (int i = count; i > slot; i--) entries[i] = entries[i-1];
            entries[slot] = val;
            count++;
          end
        end
        OP_POP: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.popped = entries[0];
            for (int i = 1; i < count; i++) entries[i-1] = entries[i];
            count--;
          end
        end
        OP_CLEAR: begin
          count = 0;
        end
        default: ;
      endcase
      r.head  = (count != 0) ? entries[0] : '0;
      r.empty = (count == 0);
      r.count = COUNT_OUT_W'(count);
      awaited.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at result beat %0d: %s", results_seen, msg);
    endtask

    task check_result(value_t popped, logic [STATUS_W-1:0] status, value_t head,
                      logic empty, logic [COUNT_OUT_W-1:0] cnt);
      pq_result_t w;
      results_seen++;
      if (awaited.size() == 0) begin
        report("result beat with no command outstanding");
        return;
      end
      w = awaited.pop_front();
      if (popped !== w.popped)
        report($sformatf("popped_value got %h want %h", popped, w.popped));
      if (status !== w.status)
        report($sformatf("status got %0d want %0d", status, w.status));
      if (head !== w.head)
        report($sformatf("head_value got %h want %h", head, w.head));
      if (empty !== w.empty)
        report($sformatf("is_empty got %b want %b", empty, w.empty));
      if (cnt !== w.count)
        report($sformatf("entry_count got %0d want %0d", cnt, w.count));
    endtask
  endclass

endpackage

// ===== tb/tb_top.sv =====
// Top of the sorted priority queue testbench: clock, reset, stimulus, back-pressure
// and the monitor feeding the shadow model. Depends on spq_pkg, pq_shadow_pkg and
// sorted_priority_queue_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;
  import pq_shadow_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_LEN    = 90;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 178;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [OP_W-1:0]        in_op;
  value_t                 in_value;
  logic                   out_valid;
  logic                   out_stall;
  value_t                 out_popped_value;
  logic [STATUS_W-1:0]    out_status;
  value_t                 out_head_value;
  logic                   out_is_empty;
  logic [COUNT_OUT_W-1:0] out_entry_count;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_order_mode;

  pq_shadow    shadow;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned quiet_cycles   = 0;

  sorted_priority_queue_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_head_value   (out_head_value),
    .out_is_empty     (out_is_empty),
    .out_entry_count  (out_entry_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_order_mode   (cfg_order_mode)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random stalls, plus a long hold whenever the stimulus asks for one.
  initial begin : receiver
    int unsigned holds_served;
    int unsigned hold_left;
    holds_served = 0;
    hold_left    = 0;
    out_stall    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_requests > holds_served) begin
        holds_served++;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) shadow.set_order(cfg_order_mode);
      if (in_valid && !in_stall) shadow.note_command(in_op, in_value);
      if (out_valid && !out_stall)
        shadow.check_result(out_popped_value, out_status, out_head_value,
                            out_is_empty, out_entry_count);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    @(posedge rst_n);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_cmd(logic [OP_W-1:0] op, value_t val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= val;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_order(logic mode);
    cfg_valid      <= 1'b1;
    cfg_order_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Small values are common so that ties and near neighbours show up often.
  function automatic value_t pick_value();
    case ($urandom_range(9))
      0:       return value_t'(32'h7FFF_FFFF);
      1:       return value_t'(32'h8000_0000);
      2:       return '0;
      3:       return '1;
      4, 5, 6: return value_t'($urandom_range(8)) - 4;
      default: return value_t'($urandom());
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 2) return OP_UNUSED;
    if (r < 5) return OP_CLEAR;
    return ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
  endfunction

  initial begin : stimulus
    int unsigned     counted;
    int unsigned     push_pct;
    logic [OP_W-1:0] op;
    shadow         = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_PUSH;
    in_value       = '0;
    cfg_valid      = 1'b0;
    cfg_order_mode = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_order(1'b0);

    send_cmd(OP_POP, value_t'(32'h1234_5678));   // pop while empty
    send_cmd(OP_PUSH, value_t'(32'h7FFF_FFFF));
    send_cmd(OP_PUSH, value_t'(32'h8000_0000));
    send_cmd(OP_PUSH, '0);
    send_cmd(OP_PUSH, '1);
    send_cmd(OP_PUSH, '0);                       // tie with a stored zero
    send_cmd(OP_UNUSED, '1);
    send_cmd(OP_POP, '0);
    // Twelve pushes fill the queue; the thirteenth must be dropped.
    repeat (13) send_cmd(OP_PUSH, pick_value());
    send_cmd(OP_POP, '0);
    send_cmd(OP_CLEAR, '1);
    send_cmd(OP_POP, '0);
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      write_order(logic'((ph % 2) ^ (ph / 4)));
      if (ph == 0 || ph == 6) hold_requests++;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        // Alternate fill-heavy and drain-heavy stretches so full and empty both recur.
        push_pct = ((counted / 40) % 2 == 0) ? 70 : 35;
        op = pick_op(push_pct);
        send_cmd(op, pick_value());
        if (op != OP_UNUSED) counted++;
      end
      drain_results();
    end

    if (shadow.mismatches == 0 && shadow.awaited.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
